// ===== rtl/core/i2cm_pkg.sv =====
// shared types, phase codes and field codes for the i2c master bit engine
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int PHASE_W = 5;

  localparam logic [PHASE_W-1:0] PH_IDLE       = 5'd0;
  localparam logic [PHASE_W-1:0] PH_ST_A       = 5'd1;
  localparam logic [PHASE_W-1:0] PH_ST_B       = 5'd2;
  localparam logic [PHASE_W-1:0] PH_ATX_LOW    = 5'd3;
  localparam logic [PHASE_W-1:0] PH_ATX_HIGH   = 5'd4;
  localparam logic [PHASE_W-1:0] PH_AACK_LOW   = 5'd5;
  localparam logic [PHASE_W-1:0] PH_AACK_HIGH  = 5'd6;
  localparam logic [PHASE_W-1:0] PH_WAIT_BYTE  = 5'd7;
  localparam logic [PHASE_W-1:0] PH_DTX_LOW    = 5'd8;
  localparam logic [PHASE_W-1:0] PH_DTX_HIGH   = 5'd9;
  localparam logic [PHASE_W-1:0] PH_DACK_LOW   = 5'd10;
  localparam logic [PHASE_W-1:0] PH_DACK_HIGH  = 5'd11;
  localparam logic [PHASE_W-1:0] PH_RX_LOW     = 5'd12;
  localparam logic [PHASE_W-1:0] PH_RX_CHECK   = 5'd13;
  localparam logic [PHASE_W-1:0] PH_RX_STRETCH = 5'd14;
  localparam logic [PHASE_W-1:0] PH_RX_HIGH    = 5'd15;
  localparam logic [PHASE_W-1:0] PH_MACK_LOW   = 5'd16;
  localparam logic [PHASE_W-1:0] PH_MACK_HIGH  = 5'd17;
  localparam logic [PHASE_W-1:0] PH_SP_A       = 5'd18;
  localparam logic [PHASE_W-1:0] PH_SP_B       = 5'd19;
  localparam logic [PHASE_W-1:0] PH_SP_C       = 5'd20;
  localparam logic [PHASE_W-1:0] PH_SP_D       = 5'd21;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_PUSH  = 2'd3;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_ADDR_NACK = 2'd1;
  localparam logic [1:0] STS_DATA_NACK = 2'd2;

  localparam logic REG_PHASE_TICKS    = 1'b0;
  localparam logic REG_STRETCH_BUDGET = 1'b1;

  localparam logic [15:0] PHASE_TICKS_RST    = 16'd1;
  localparam logic [7:0]  STRETCH_BUDGET_RST = 8'd10;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [7:0]  stretch_budget;
  } i2cm_cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [15:0]        tick_count;
    logic [3:0]         bit_index;
    logic [7:0]         shift_reg;
    logic [7:0]         bytes_left;
    logic               is_read;
    logic [7:0]         hold_byte;
    logic               hold_full;
    logic [7:0]         stretch_used;
    logic [1:0]         result_code;
  } i2cm_state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] dev_addr;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;
    logic       scl_in;
  } i2cm_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       byte_request;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       done_res;
    logic [1:0] status;
  } i2cm_res_t;

  localparam i2cm_state_t STATE_RST = '{
    phase:        PH_IDLE,
    tick_count:   16'd0,
    bit_index:    4'd0,
    shift_reg:    8'd0,
    bytes_left:   8'd0,
    is_read:      1'b0,
    hold_byte:    8'd0,
    hold_full:    1'b0,
    stretch_used: 8'd0,
    result_code:  STS_OK
  };

endpackage

// ===== rtl/core/i2c_master_bit_engine_top.sv =====
// top level of the i2c master bit engine: item register, sequencer state, result register
`timescale 1ns / 1ps

//  channel  | ports                                   | moves
//  ---------+-----------------------------------------+---------------------------------
//  in       | in_valid, in_stall, in_<field>          | one tick item: action and bus levels
//  out      | out_valid, out_stall, out_<field>       | one result item per tick item
//  cfg      | psel, penable, pwrite, paddr, pwdata... | phase_ticks at 0x0, budget at 0x4
//
// one item a cycle while out does not stall: an item is held in the input register, and its
// result is then registered in the result register.
// sequencer state updates once per item in a single pass of the step logic.
// rst_n is synchronous; it empties both registers and returns the bus to idle.
// a stall on out holds the result; in then stalls only once its register is full.

module i2c_master_bit_engine_top
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [6:0]  in_dev_addr,
  input  logic [7:0]  in_byte_count,
  input  logic [7:0]  in_write_byte,
  input  logic        in_sda_in,
  input  logic        in_scl_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_busy_res,
  output logic        out_byte_request,
  output logic [7:0]  out_read_byte,
  output logic        out_read_valid,
  output logic        out_done_res,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  i2cm_cfg_t   cfg;
  i2cm_state_t state_r;
  i2cm_state_t state_nxt;
  i2cm_item_t  item_r;
  i2cm_res_t   res_nxt;
  i2cm_res_t   res_r;
  logic        item_vld_r;
  logic        out_vld_r;
  logic        step_go;
  logic        item_load;

  i2cm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2cm_step u_step (
    .st     (state_r),
    .cfg    (cfg),
    .item   (item_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // item moves on when the result register is free or being emptied
  assign step_go   = item_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = item_vld_r && !step_go;
  assign item_load = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      state_r    <= STATE_RST;
    end else begin
      if (item_load)    item_vld_r <= 1'b1;
      else if (step_go) item_vld_r <= 1'b0;
      if (step_go)        out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;
      if (step_go) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      item_r.action     <= in_action;
      item_r.dev_addr   <= in_dev_addr;
      item_r.byte_count <= in_byte_count;
      item_r.write_byte <= in_write_byte;
      item_r.sda_in     <= in_sda_in;
      item_r.scl_in     <= in_scl_in;
    end
    if (step_go) res_r <= res_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_scl_out      = res_r.scl_out;
  assign out_sda_out      = res_r.sda_out;
  assign out_busy_res     = res_r.busy_res;
  assign out_byte_request = res_r.byte_request;
  assign out_read_byte    = res_r.read_byte;
  assign out_read_valid   = res_r.read_valid;
  assign out_done_res     = res_r.done_res;
  assign out_status       = res_r.status;

endmodule

// ===== rtl/core/i2cm_regs.sv =====
// apb-style configuration registers: phase delay and stretch budget
`timescale 1ns / 1ps

module i2cm_regs
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output i2cm_cfg_t   cfg
);

  logic [15:0] phase_ticks_r;
  logic [7:0]  stretch_budget_r;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  // register index is the word address
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r    <= PHASE_TICKS_RST;
      stretch_budget_r <= STRETCH_BUDGET_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PHASE_TICKS:    phase_ticks_r    <= pwdata[15:0];
        REG_STRETCH_BUDGET: stretch_budget_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PHASE_TICKS:    prdata = {16'd0, phase_ticks_r};
      REG_STRETCH_BUDGET: prdata = {24'd0, stretch_budget_r};
      default:            prdata = 32'd0;
    endcase
  end

  assign cfg.phase_ticks    = phase_ticks_r;
  assign cfg.stretch_budget = stretch_budget_r;

endmodule

// ===== rtl/core/i2cm_step.sv =====
// next-state and result logic for one tick item of the bus sequencer
`timescale 1ns / 1ps

module i2cm_step
  import i2cm_pkg::*;
(
  input  i2cm_state_t st,
  input  i2cm_cfg_t   cfg,
  input  i2cm_item_t  item,
  output i2cm_state_t st_nxt,
  output i2cm_res_t   res
);

  function automatic i2cm_state_t enter(input i2cm_state_t s, input logic [PHASE_W-1:0] p);
    i2cm_state_t r;
    r            = s;
    r.phase      = p;
    r.tick_count = 16'd0;
    return r;
  endfunction

  // pick the next data byte, stop, or wait for the host to push one
  function automatic i2cm_state_t next_write(input i2cm_state_t s);
    i2cm_state_t r;
    r = s;
    if (s.bytes_left == 8'd0) begin
      r = enter(s, PH_SP_A);
    end else if (s.hold_full) begin
      r.shift_reg  = s.hold_byte;
      r.hold_full  = 1'b0;
      r.bytes_left = s.bytes_left - 8'd1;
      r.bit_index  = 4'd0;
      r = enter(r, PH_DTX_LOW);
    end else begin
      r = enter(s, PH_WAIT_BYTE);
    end
    return r;
  endfunction

  i2cm_state_t ns;
  logic [15:0] tick_inc;
  logic [3:0]  bit_inc;
  logic        timed;
  logic        ended;
  logic        rvalid;
  logic [7:0]  rbyte;
  logic        done;
  logic        scl;
  logic        sda;

  assign tick_inc = st.tick_count + 16'd1;
  assign bit_inc  = st.bit_index + 4'd1;
  assign timed    = (st.phase != PH_IDLE) && (st.phase != PH_WAIT_BYTE) &&
                    (st.phase != PH_RX_CHECK);

  always_comb begin
    ns     = st;
    ended  = 1'b0;
    rvalid = 1'b0;
    rbyte  = 8'd0;
    done   = 1'b0;
    if (st.phase == PH_IDLE) begin
      if (item.action == ACT_WRITE || item.action == ACT_READ) begin
        ns.is_read      = (item.action == ACT_READ);
        ns.shift_reg    = {item.dev_addr, item.action == ACT_READ};
        ns.bytes_left   = item.byte_count;
        ns.bit_index    = 4'd0;
        ns.hold_full    = 1'b0;
        ns.stretch_used = 8'd0;
        ns.result_code  = STS_OK;
        ns = enter(ns, PH_ST_A);
      end
    end else begin
      // a push lands before the tick moves the bus
      if (item.action == ACT_PUSH && !st.is_read && !st.hold_full &&
          st.bytes_left != 8'd0) begin
        ns.hold_byte = item.write_byte;
        ns.hold_full = 1'b1;
      end
      if (timed) begin
        ns.tick_count = tick_inc;
        ended         = (tick_inc >= cfg.phase_ticks);
      end
      if (st.phase == PH_WAIT_BYTE) begin
        if (ns.hold_full) ns = next_write(ns);
      end else if (st.phase == PH_RX_CHECK) begin
        if (item.scl_in || st.stretch_used >= cfg.stretch_budget) begin
          ns.shift_reg = {st.shift_reg[6:0], item.sda_in};
          ns = enter(ns, PH_RX_HIGH);
        end else begin
          ns = enter(ns, PH_RX_STRETCH);
        end
      end
      if (ended) begin
        unique case (st.phase) inside
          PH_ST_A:     ns = enter(ns, PH_ST_B);
          PH_ST_B:     ns = enter(ns, PH_ATX_LOW);
          PH_ATX_LOW:  ns = enter(ns, PH_ATX_HIGH);
          PH_DTX_LOW:  ns = enter(ns, PH_DTX_HIGH);
          PH_ATX_HIGH, PH_DTX_HIGH: begin
            ns.shift_reg = {st.shift_reg[6:0], 1'b0};
            ns.bit_index = bit_inc;
            if (bit_inc >= 4'd8)
              ns = enter(ns, (st.phase == PH_ATX_HIGH) ? PH_AACK_LOW : PH_DACK_LOW);
            else
              ns = enter(ns, (st.phase == PH_ATX_HIGH) ? PH_ATX_LOW : PH_DTX_LOW);
          end
          PH_AACK_LOW: ns = enter(ns, PH_AACK_HIGH);
          PH_DACK_LOW: ns = enter(ns, PH_DACK_HIGH);
          PH_AACK_HIGH: begin
            if (item.sda_in) begin
              ns.result_code = STS_ADDR_NACK;
              ns = enter(ns, PH_SP_A);
            end else if (st.is_read) begin
              if (st.bytes_left == 8'd0) begin
                ns = enter(ns, PH_SP_A);
              end else begin
                ns.shift_reg = 8'd0;
                ns.bit_index = 4'd0;
                ns = enter(ns, PH_RX_LOW);
              end
            end else begin
              ns = next_write(ns);
            end
          end
          PH_DACK_HIGH: begin
            if (item.sda_in) begin
              ns.result_code = STS_DATA_NACK;
              ns = enter(ns, PH_SP_A);
            end else begin
              ns = next_write(ns);
            end
          end
          PH_RX_LOW: ns = enter(ns, PH_RX_CHECK);
          PH_RX_STRETCH: begin
            ns.stretch_used = st.stretch_used + 8'd1;
            ns = enter(ns, PH_RX_CHECK);
          end
          PH_RX_HIGH: begin
            ns.bit_index = bit_inc;
            if (bit_inc >= 4'd8) begin
              ns.bytes_left = st.bytes_left - 8'd1;
              rvalid        = 1'b1;
              rbyte         = st.shift_reg;
              ns = enter(ns, PH_MACK_LOW);
            end else begin
              ns = enter(ns, PH_RX_LOW);
            end
          end
          PH_MACK_LOW: ns = enter(ns, PH_MACK_HIGH);
          PH_MACK_HIGH: begin
            if (st.bytes_left == 8'd0) begin
              ns = enter(ns, PH_SP_A);
            end else begin
              ns.shift_reg = 8'd0;
              ns.bit_index = 4'd0;
              ns = enter(ns, PH_RX_LOW);
            end
          end
          PH_SP_A: ns = enter(ns, PH_SP_B);
          PH_SP_B: ns = enter(ns, PH_SP_C);
          PH_SP_C: ns = enter(ns, PH_SP_D);
          PH_SP_D: begin
            done         = 1'b1;
            ns.hold_full = 1'b0;
            ns = enter(ns, PH_IDLE);
          end
          default: ns = enter(ns, PH_IDLE);
        endcase
      end
    end
  end

  // line drive follows the phase after the tick
  always_comb begin
    unique case (ns.phase) inside
      PH_ST_A: begin
        scl = 1'b1;
        sda = 1'b0;
      end
      PH_ST_B, PH_SP_A: begin
        scl = 1'b0;
        sda = 1'b0;
      end
      PH_ATX_LOW, PH_DTX_LOW: begin
        scl = 1'b0;
        sda = ns.shift_reg[7];
      end
      PH_ATX_HIGH, PH_DTX_HIGH: begin
        scl = 1'b1;
        sda = ns.shift_reg[7];
      end
      PH_AACK_LOW, PH_DACK_LOW, PH_WAIT_BYTE, PH_RX_LOW: begin
        scl = 1'b0;
        sda = 1'b1;
      end
      PH_MACK_LOW: begin
        scl = 1'b0;
        sda = (ns.bytes_left == 8'd0);
      end
      PH_MACK_HIGH: begin
        scl = 1'b1;
        sda = (ns.bytes_left == 8'd0);
      end
      PH_SP_B: begin
        scl = 1'b1;
        sda = 1'b0;
      end
      default: begin
        scl = 1'b1;
        sda = 1'b1;
      end
    endcase
  end

  assign st_nxt           = ns;
  assign res.scl_out      = scl;
  assign res.sda_out      = sda;
  assign res.busy_res     = (ns.phase != PH_IDLE);
  assign res.byte_request = (ns.phase != PH_IDLE) && !ns.is_read && !ns.hold_full &&
                            (ns.bytes_left != 8'd0);
  assign res.read_byte    = rbyte;
  assign res.read_valid   = rvalid;
  assign res.done_res     = done;
  assign res.status       = ns.result_code;

endmodule

// ===== dv/tb_i2c_master_bit_engine_top.sv =====
// self-checking testbench for the i2c master bit engine top level
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine_top;
  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int N_ROWS = 25;
  localparam int N_SETTINGS = 7;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // one line of the directed table: an item, how often it repeats, an optional fixed result
  typedef struct packed {
    logic [1:0] action;
    logic [6:0] dev_addr;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;
    logic       scl_in;
    logic [7:0] reps;
    logic       typed;
    i2cm_res_t  res;
  } dir_row_t;

  localparam i2cm_res_t RES_IDLE = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
    byte_request: 1'b0, read_byte: 8'h00, read_valid: 1'b0, done_res: 1'b0, status: STS_OK};
  localparam i2cm_res_t RES_START_REQ = '{scl_out: 1'b1, sda_out: 1'b0, busy_res: 1'b1,
    byte_request: 1'b1, read_byte: 8'h00, read_valid: 1'b0, done_res: 1'b0, status: STS_OK};
  localparam i2cm_res_t RES_START_NOREQ = '{scl_out: 1'b1, sda_out: 1'b0, busy_res: 1'b1,
    byte_request: 1'b0, read_byte: 8'h00, read_valid: 1'b0, done_res: 1'b0, status: STS_OK};

  localparam dir_row_t DIR_TABLE [N_ROWS] = '{
    // idle tick and a push with nothing going on
    '{ACT_TICK,  7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'd1,  1'b1, RES_IDLE},
    '{ACT_PUSH,  7'h00, 8'h00, 8'hFF, 1'b1, 1'b1, 8'd1,  1'b1, RES_IDLE},
    // two-byte write, start while busy, bus held until a byte is pushed
    '{ACT_WRITE, 7'h7F, 8'd2,  8'h00, 1'b0, 1'b1, 8'd1,  1'b1, RES_START_REQ},
    '{ACT_READ,  7'h00, 8'd5,  8'h00, 1'b0, 1'b1, 8'd1,  1'b0, '0},
    '{ACT_TICK,  7'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'd30, 1'b0, '0},
    '{ACT_PUSH,  7'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'd1,  1'b0, '0},
    '{ACT_PUSH,  7'h00, 8'h00, 8'hFF, 1'b0, 1'b1, 8'd1,  1'b0, '0},
    '{ACT_PUSH,  7'h00, 8'h00, 8'h5A, 1'b0, 1'b1, 8'd1,  1'b0, '0},
    '{ACT_TICK,  7'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'd50, 1'b0, '0},
    // read with scl held low until the wait budget runs out
    '{ACT_READ,  7'h00, 8'd1,  8'h00, 1'b0, 1'b0, 8'd1,  1'b1, RES_START_NOREQ},
    '{ACT_TICK,  7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'd20, 1'b0, '0},
    '{ACT_TICK,  7'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'd60, 1'b0, '0},
    // plain two-byte read
    '{ACT_READ,  7'h7F, 8'd2,  8'h00, 1'b0, 1'b1, 8'd1,  1'b1, RES_START_NOREQ},
    '{ACT_TICK,  7'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'd20, 1'b0, '0},
    '{ACT_TICK,  7'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'd30, 1'b0, '0},
    '{ACT_TICK,  7'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'd40, 1'b0, '0},
    // zero-length write goes straight to stop
    '{ACT_WRITE, 7'h2A, 8'd0,  8'h00, 1'b0, 1'b1, 8'd1,  1'b1, RES_START_NOREQ},
    '{ACT_TICK,  7'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'd30, 1'b0, '0},
    // full-length write cut short by a data nack
    '{ACT_WRITE, 7'h55, 8'hFF, 8'h00, 1'b0, 1'b1, 8'd1,  1'b1, RES_START_REQ},
    '{ACT_PUSH,  7'h00, 8'h00, 8'hFF, 1'b0, 1'b1, 8'd1,  1'b0, '0},
    '{ACT_TICK,  7'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'd36, 1'b0, '0},
    '{ACT_TICK,  7'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'd30, 1'b0, '0},
    // address nack on a read
    '{ACT_READ,  7'h2A, 8'd3,  8'h00, 1'b1, 1'b1, 8'd1,  1'b1, RES_START_NOREQ},
    '{ACT_TICK,  7'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'd30, 1'b0, '0},
    '{ACT_TICK,  7'h7F, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'd2,  1'b0, '0}
  };

  localparam logic [15:0] TICKS_SET [N_SETTINGS] = '{16'd1, 16'd2, 16'd0, 16'd65535,
    16'd3, 16'd1, 16'd1};
  localparam logic [7:0] BUDGET_SET [N_SETTINGS] = '{8'd10, 8'd0, 8'd255, 8'd3,
    8'd7, 8'd255, 8'd0};
  localparam int ITEMS_SET [N_SETTINGS] = '{220, 180, 150, 40, 180, 150, 240};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_TICK;
  logic [6:0]  in_dev_addr = '0;
  logic [7:0]  in_byte_count = '0;
  logic [7:0]  in_write_byte = '0;
  logic        in_sda_in = 1'b1;
  logic        in_scl_in = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_scl_out;
  logic        out_sda_out;
  logic        out_busy_res;
  logic        out_byte_request;
  logic [7:0]  out_read_byte;
  logic        out_read_valid;
  logic        out_done_res;
  logic [1:0]  out_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  i2cm_state_t bus_st;
  i2cm_cfg_t   cfg_model;
  i2cm_res_t   bus_results_due [$];
  i2cm_res_t   seen_res;
  i2cm_res_t   due_res;
  i2cm_item_t  cur_item;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned stall_span = 0;
  stall_mode_t stall_mode = STALL_NONE;
  logic [7:0]  stall_phase = '0;
  logic [15:0] ticks_val;
  logic [7:0]  budget_val;

  i2c_master_bit_engine_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_dev_addr      (in_dev_addr),
    .in_byte_count    (in_byte_count),
    .in_write_byte    (in_write_byte),
    .in_sda_in        (in_sda_in),
    .in_scl_in        (in_scl_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scl_out      (out_scl_out),
    .out_sda_out      (out_sda_out),
    .out_busy_res     (out_busy_res),
    .out_byte_request (out_byte_request),
    .out_read_byte    (out_read_byte),
    .out_read_valid   (out_read_valid),
    .out_done_res     (out_done_res),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void enter_phase(input logic [PHASE_W-1:0] p);
    bus_st.phase = p;
    bus_st.tick_count = '0;
  endfunction

  // after an ack on a write: stop, load the held byte, or wait for one
  function automatic void load_next_write();
    if (bus_st.bytes_left == 8'd0) begin
      enter_phase(PH_SP_A);
    end else if (bus_st.hold_full) begin
      bus_st.shift_reg = bus_st.hold_byte;
      bus_st.hold_full = 1'b0;
      bus_st.bytes_left = bus_st.bytes_left - 8'd1;
      bus_st.bit_index = '0;
      enter_phase(PH_DTX_LOW);
    end else begin
      enter_phase(PH_WAIT_BYTE);
    end
  endfunction

  task automatic advance_bus(input i2cm_item_t it, output i2cm_res_t r);
    logic ended;
    logic [PHASE_W-1:0] ph;
    ended = 1'b0;
    r = '0;
    if (bus_st.phase == PH_IDLE) begin
      if (it.action == ACT_WRITE || it.action == ACT_READ) begin
        bus_st.is_read = (it.action == ACT_READ);
        bus_st.shift_reg = {it.dev_addr, bus_st.is_read};
        bus_st.bytes_left = it.byte_count;
        bus_st.bit_index = '0;
        bus_st.hold_full = 1'b0;
        bus_st.stretch_used = '0;
        bus_st.result_code = STS_OK;
        enter_phase(PH_ST_A);
      end
    end else begin
      // a push lands before the tick moves the bus on
      if (it.action == ACT_PUSH && !bus_st.is_read && !bus_st.hold_full &&
          bus_st.bytes_left != 8'd0) begin
        bus_st.hold_byte = it.write_byte;
        bus_st.hold_full = 1'b1;
      end
      if (bus_st.phase != PH_WAIT_BYTE && bus_st.phase != PH_RX_CHECK) begin
        bus_st.tick_count = bus_st.tick_count + 16'd1;
        ended = (bus_st.tick_count >= cfg_model.phase_ticks);
      end
      case (bus_st.phase)
        PH_WAIT_BYTE: if (bus_st.hold_full) load_next_write();
        PH_RX_CHECK: begin
          if (it.scl_in || bus_st.stretch_used >= cfg_model.stretch_budget) begin
            bus_st.shift_reg = {bus_st.shift_reg[6:0], it.sda_in};
            enter_phase(PH_RX_HIGH);
          end else begin
            enter_phase(PH_RX_STRETCH);
          end
        end
        default: ;
      endcase
      if (ended) begin
        ph = bus_st.phase;
        case (ph)
          PH_ST_A:     enter_phase(PH_ST_B);
          PH_ST_B:     enter_phase(PH_ATX_LOW);
          PH_ATX_LOW:  enter_phase(PH_ATX_HIGH);
          PH_DTX_LOW:  enter_phase(PH_DTX_HIGH);
          PH_ATX_HIGH, PH_DTX_HIGH: begin
            bus_st.shift_reg = {bus_st.shift_reg[6:0], 1'b0};
            bus_st.bit_index = bus_st.bit_index + 4'd1;
            if (bus_st.bit_index >= 4'd8) begin
              enter_phase(ph == PH_ATX_HIGH ? PH_AACK_LOW : PH_DACK_LOW);
            end else begin
              enter_phase(ph == PH_ATX_HIGH ? PH_ATX_LOW : PH_DTX_LOW);
            end
          end
          PH_AACK_LOW: enter_phase(PH_AACK_HIGH);
          PH_DACK_LOW: enter_phase(PH_DACK_HIGH);
          PH_AACK_HIGH: begin
            if (it.sda_in) begin
              bus_st.result_code = STS_ADDR_NACK;
              enter_phase(PH_SP_A);
            end else if (bus_st.is_read) begin
              if (bus_st.bytes_left == 8'd0) begin
                enter_phase(PH_SP_A);
              end else begin
                bus_st.shift_reg = '0;
                bus_st.bit_index = '0;
                enter_phase(PH_RX_LOW);
              end
            end else begin
              load_next_write();
            end
          end
          PH_DACK_HIGH: begin
            if (it.sda_in) begin
              bus_st.result_code = STS_DATA_NACK;
              enter_phase(PH_SP_A);
            end else begin
              load_next_write();
            end
          end
          PH_RX_LOW: enter_phase(PH_RX_CHECK);
          PH_RX_STRETCH: begin
            bus_st.stretch_used = bus_st.stretch_used + 8'd1;
            enter_phase(PH_RX_CHECK);
          end
          PH_RX_HIGH: begin
            bus_st.bit_index = bus_st.bit_index + 4'd1;
            if (bus_st.bit_index >= 4'd8) begin
              bus_st.bytes_left = bus_st.bytes_left - 8'd1;
              r.read_valid = 1'b1;
              r.read_byte = bus_st.shift_reg;
              enter_phase(PH_MACK_LOW);
            end else begin
              enter_phase(PH_RX_LOW);
            end
          end
          PH_MACK_LOW: enter_phase(PH_MACK_HIGH);
          PH_MACK_HIGH: begin
            if (bus_st.bytes_left == 8'd0) begin
              enter_phase(PH_SP_A);
            end else begin
              bus_st.shift_reg = '0;
              bus_st.bit_index = '0;
              enter_phase(PH_RX_LOW);
            end
          end
          PH_SP_A: enter_phase(PH_SP_B);
          PH_SP_B: enter_phase(PH_SP_C);
          PH_SP_C: enter_phase(PH_SP_D);
          PH_SP_D: begin
            r.done_res = 1'b1;
            bus_st.hold_full = 1'b0;
            enter_phase(PH_IDLE);
          end
          default: enter_phase(PH_IDLE);
        endcase
      end
    end

    // line drive follows the phase reached after this tick
    case (bus_st.phase)
      PH_ST_A: begin r.scl_out = 1'b1; r.sda_out = 1'b0; end
      PH_ST_B, PH_SP_A: begin r.scl_out = 1'b0; r.sda_out = 1'b0; end
      PH_SP_B: begin r.scl_out = 1'b1; r.sda_out = 1'b0; end
      PH_ATX_LOW, PH_DTX_LOW: begin
        r.scl_out = 1'b0;
        r.sda_out = bus_st.shift_reg[7];
      end
      PH_ATX_HIGH, PH_DTX_HIGH: begin
        r.scl_out = 1'b1;
        r.sda_out = bus_st.shift_reg[7];
      end
      PH_AACK_LOW, PH_DACK_LOW, PH_WAIT_BYTE, PH_RX_LOW: begin
        r.scl_out = 1'b0;
        r.sda_out = 1'b1;
      end
      PH_MACK_LOW: begin
        r.scl_out = 1'b0;
        r.sda_out = (bus_st.bytes_left == 8'd0);
      end
      PH_MACK_HIGH: begin
        r.scl_out = 1'b1;
        r.sda_out = (bus_st.bytes_left == 8'd0);
      end
      default: begin r.scl_out = 1'b1; r.sda_out = 1'b1; end
    endcase
    r.busy_res = (bus_st.phase != PH_IDLE);
    r.byte_request = r.busy_res && !bus_st.is_read && !bus_st.hold_full &&
                     bus_st.bytes_left != 8'd0;
    r.status = bus_st.result_code;
  endtask

  // mostly well-formed transactions, steered by where the engine is now
  function automatic i2cm_item_t next_bus_item();
    i2cm_item_t it;
    logic want_byte;
    it.action = ACT_TICK;
    it.dev_addr = 7'($urandom_range(0, 127));
    it.byte_count = 8'($urandom_range(0, 3));
    it.write_byte = 8'($urandom_range(0, 255));
    it.sda_in = 1'($urandom_range(0, 1));
    it.scl_in = ($urandom_range(0, 4) != 0);
    want_byte = bus_st.phase != PH_IDLE && !bus_st.is_read && !bus_st.hold_full &&
                bus_st.bytes_left != 8'd0;
    if ($urandom_range(0, 11) == 0) begin
      it.action = 2'($urandom_range(0, 3));
      it.scl_in = 1'($urandom_range(0, 1));
      // long reads cannot be cut short, so only writes get the full count range
      if (it.action != ACT_READ) it.byte_count = 8'($urandom_range(0, 255));
    end else if (bus_st.phase == PH_IDLE) begin
      if ($urandom_range(0, 9) < 7) begin
        it.action = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
        if ($urandom_range(0, 7) == 0) it.byte_count = 8'($urandom_range(4, 12));
      end
    end else begin
      if (want_byte && $urandom_range(0, 9) < 6) it.action = ACT_PUSH;
      case (bus_st.phase)
        PH_AACK_HIGH, PH_DACK_HIGH: it.sda_in = ($urandom_range(0, 9) == 0);
        PH_RX_CHECK: it.scl_in = ($urandom_range(0, 9) < 6);
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic send_item(input i2cm_item_t it, input logic typed, input i2cm_res_t fixed);
    i2cm_res_t pred;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= it.action;
    in_dev_addr <= it.dev_addr;
    in_byte_count <= it.byte_count;
    in_write_byte <= it.write_byte;
    in_sda_in <= it.sda_in;
    in_scl_in <= it.scl_in;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    advance_bus(it, pred);
    bus_results_due.push_back(typed ? fixed : pred);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (bus_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_PHASE_TICKS) cfg_model.phase_ticks = value[15:0];
    else cfg_model.stretch_budget = value[7:0];
    @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // result checking and the receiver's own stall pattern
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_res = {out_scl_out, out_sda_out, out_busy_res, out_byte_request,
                    out_read_byte, out_read_valid, out_done_res, out_status};
        if (bus_results_due.size() == 0) begin
          $error("result item with none expected");
          mismatches++;
        end else begin
          due_res = bus_results_due.pop_front();
          compare_field("scl_out", 8'(due_res.scl_out), 8'(seen_res.scl_out));
          compare_field("sda_out", 8'(due_res.sda_out), 8'(seen_res.sda_out));
          compare_field("busy_res", 8'(due_res.busy_res), 8'(seen_res.busy_res));
          compare_field("byte_request", 8'(due_res.byte_request),
                        8'(seen_res.byte_request));
          compare_field("read_byte", due_res.read_byte, seen_res.read_byte);
          compare_field("read_valid", 8'(due_res.read_valid), 8'(seen_res.read_valid));
          compare_field("done_res", 8'(due_res.done_res), 8'(seen_res.done_res));
          compare_field("status", 8'(due_res.status), 8'(seen_res.status));
        end
      end
      if (stall_span == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_span = $urandom_range(8, 64);
      end
      stall_span--;
      stall_phase = stall_phase + 8'd1;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 2) != 0);
        default:     out_stall <= (stall_phase[1:0] == 2'b11);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_i2c_master_bit_engine_top: FAIL");
      $finish;
    end
  end

  initial begin
    bus_st = STATE_RST;
    cfg_model.phase_ticks = PHASE_TICKS_RST;
    cfg_model.stretch_budget = STRETCH_BUDGET_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table under the reset settings
    for (int r = 0; r < N_ROWS; r++) begin
      cur_item = {DIR_TABLE[r].action, DIR_TABLE[r].dev_addr, DIR_TABLE[r].byte_count,
                  DIR_TABLE[r].write_byte, DIR_TABLE[r].sda_in, DIR_TABLE[r].scl_in};
      for (int k = 0; k < int'(DIR_TABLE[r].reps); k++) begin
        // a fixed result only holds for the first item of a row
        send_item(cur_item, DIR_TABLE[r].typed && k == 0, DIR_TABLE[r].res);
      end
    end
    drain_results();

    // random traffic under a series of timing and wait-budget settings
    for (int s = 0; s < N_SETTINGS; s++) begin
      ticks_val = TICKS_SET[s];
      budget_val = BUDGET_SET[s];
      if (s == N_SETTINGS - 1) begin
        ticks_val = 16'($urandom_range(1, 4));
        budget_val = 8'($urandom_range(0, 255));
      end
      write_reg(REG_PHASE_TICKS, {16'd0, ticks_val});
      write_reg(REG_STRETCH_BUDGET, {24'd0, budget_val});
      for (int n = 0; n < ITEMS_SET[s]; n++) begin
        send_item(next_bus_item(), 1'b0, '0);
      end
      drain_results();
    end

    if (mismatches == 0) begin
      $display("tb_i2c_master_bit_engine_top: PASS");
    end else begin
      $display("tb_i2c_master_bit_engine_top: FAIL");
    end
    $finish;
  end

endmodule
